// File: rtl/ptq_pkg.sv
// Shared types, codes and constants for the priority transmit queue.
// No dependencies; imported by every module of the block except ptq_ram.
`timescale 1ns / 1ps

package ptq_pkg;

    // defaults for the top-level parameters
    localparam int QUEUE_DEPTH_DEF = 128;
    localparam int NUM_PRIO_DEF    = 3;

    // queue index carried between modules: enough for up to 8 priorities
    localparam int QIDX_W   = 3;
    localparam int NORMAL_Q = 1;

    localparam int BID_W  = 8;
    localparam int LEN_W  = 11;
    localparam int DESC_W = BID_W + LEN_W;
    localparam int PEND_W = 8;
    localparam int OPRI_W = 2;

    localparam int TDATA_W    = 32;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [PEND_W-1:0] MAX_PENDING_RST = 8'd100;
    localparam logic [PEND_W-1:0] RESUME_THR_RST  = 8'd20;

    // request queue between front and back
    localparam int FQ_DEPTH = 2;
    localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
    localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);

    typedef logic [QIDX_W-1:0] t_qidx;

    typedef enum logic [1:0] {
        REQ_ENQ   = 2'd0,
        REQ_DEQ   = 2'd1,
        REQ_FLUSH = 2'd2,
        REQ_NOP   = 2'd3
    } t_req;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_BUSY  = 2'd1,
        ST_FULL  = 2'd2,
        ST_EMPTY = 2'd3
    } t_status;

    typedef enum logic {
        CFG_MAX_PENDING = 1'b0,
        CFG_RESUME_THR  = 1'b1
    } t_cfg_idx;

    typedef enum logic {
        BS_IDLE = 1'b0,
        BS_READ = 1'b1
    } t_bstate;

    // classified request handed from front to back
    typedef struct packed {
        t_req             kind;
        t_qidx            q;
        logic [BID_W-1:0] bid;
        logic [LEN_W-1:0] flen;
    } t_cmd;

    typedef struct packed {
        t_status           status;
        logic [BID_W-1:0]  bid;
        logic [LEN_W-1:0]  flen;
        logic [OPRI_W-1:0] prio;
        logic              paused;
        logic [PEND_W-1:0] pend;
    } t_result;

endpackage

// File: rtl/ptq_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module ptq_ram #(
    parameter int WIDTH = 19,
    parameter int DEPTH = 384
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: rtl/ptq_front.sv
// Front end: accepts request transactions, maps the priority and queues the
// classified command for the back end. Depends on ptq_pkg.
`timescale 1ns / 1ps

module ptq_front import ptq_pkg::*; #(
    parameter int NUM_PRIORITIES = NUM_PRIO_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_tvalid,
    output logic               o_tready,
    input  logic [1:0]         i_tuser,   // req_type
    input  logic [TDATA_W-1:0] i_tdata,   // priority_req, buffer_id, frame_length
    output logic               o_cmd_valid,
    output t_cmd               o_cmd,
    input  logic               i_cmd_pop
);

    t_cmd                r_fq [FQ_DEPTH];
    logic [FQ_PTR_W-1:0] r_wr_ptr;
    logic [FQ_PTR_W-1:0] r_rd_ptr;
    logic [FQ_CNT_W-1:0] r_count;
    t_cmd                w_cmd_in;
    logic                w_push;
    logic                w_pop;

    // out-of-range priorities fall back to the normal queue
    always_comb begin
        w_cmd_in.kind = t_req'(i_tuser);
        w_cmd_in.q    = (i_tdata[7:0] >= 8'(NUM_PRIORITIES)) ? t_qidx'(NORMAL_Q)
                                                              : i_tdata[QIDX_W-1:0];
        w_cmd_in.bid  = i_tdata[15:8];
        w_cmd_in.flen = i_tdata[26:16];
    end

    assign o_tready    = (r_count != FQ_CNT_W'(FQ_DEPTH));
    assign w_push      = i_tvalid && o_tready;
    assign o_cmd_valid = (r_count != '0);
    assign w_pop       = i_cmd_pop && o_cmd_valid;
    assign o_cmd       = r_fq[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) begin
                r_wr_ptr <= (r_wr_ptr == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= (r_rd_ptr == FQ_PTR_W'(FQ_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (w_push && !w_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_pop && !w_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fq[r_wr_ptr] <= w_cmd_in;
        end
    end

endmodule

// File: rtl/ptq_back.sv
// Back end: queue pointers, occupancy, flow control, descriptor store and the
// result register. Depends on ptq_pkg and ptq_ram.
`timescale 1ns / 1ps

module ptq_back import ptq_pkg::*; #(
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
    parameter int NUM_PRIORITIES = NUM_PRIO_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cmd_valid,
    input  t_cmd              i_cmd,
    output logic              o_cmd_pop,
    input  logic [PEND_W-1:0] i_max_pending,
    input  logic [PEND_W-1:0] i_resume_thr,
    output logic              o_res_valid,
    output t_result           o_res,
    input  logic              i_res_ready
);

    localparam int PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int OCC_W     = $clog2(QUEUE_DEPTH + 1);
    localparam int QI_W      = $clog2(NUM_PRIORITIES);
    localparam int RAM_DEPTH = NUM_PRIORITIES * QUEUE_DEPTH;
    localparam int ADDR_W    = $clog2(RAM_DEPTH);

    logic [PTR_W-1:0]  r_head [NUM_PRIORITIES];
    logic [PTR_W-1:0]  r_tail [NUM_PRIORITIES];
    logic [OCC_W-1:0]  r_occ  [NUM_PRIORITIES];
    logic [PEND_W-1:0] r_pend;
    logic [PEND_W-1:0] n_pend;
    logic              r_paused;
    logic              n_paused;
    t_bstate           r_state;
    t_bstate           n_state;
    logic              r_res_valid;
    t_result           r_res;
    t_qidx             r_deq_q;

    logic              w_exec;
    logic              w_found;
    t_qidx             w_sel;
    t_qidx             w_q;
    logic [QI_W-1:0]   w_qi;
    logic              w_normal;
    logic [PTR_W-1:0]  w_ptr;
    logic [ADDR_W-1:0] w_addr;
    logic              w_ram_we;
    logic              w_ram_re;
    logic [DESC_W-1:0] w_ram_rd;
    logic              w_enq_ok;
    logic              w_deq_ok;
    logic              w_flush;
    logic              w_res_load;
    t_result           w_res_d;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign w_exec    = i_cmd_valid && (r_state == BS_IDLE) && (!r_res_valid || i_res_ready);
    assign o_cmd_pop = w_exec;

    // lowest-numbered non-empty queue
    always_comb begin
        w_found = 1'b0;
        w_sel   = '0;
        for (int i = NUM_PRIORITIES - 1; i >= 0; i--) begin
            if (r_occ[i] != '0) begin
                w_found = 1'b1;
                w_sel   = t_qidx'(i);
            end
        end
    end

    assign w_q      = (i_cmd.kind == REQ_DEQ) ? w_sel : i_cmd.q;
    assign w_qi     = w_q[QI_W-1:0];
    assign w_normal = (w_q == t_qidx'(NORMAL_Q));
    assign w_ptr    = (i_cmd.kind == REQ_DEQ) ? r_head[w_qi] : r_tail[w_qi];
    assign w_addr   = ADDR_W'(w_qi) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(w_ptr);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BS_IDLE: begin
                if (w_exec && i_cmd.kind == REQ_DEQ && w_found) begin
                    n_state = BS_READ;
                end
            end
            BS_READ: n_state = BS_IDLE;
            default: n_state = BS_IDLE;
        endcase
    end

    // command execution and result
    always_comb begin
        w_ram_we   = 1'b0;
        w_ram_re   = 1'b0;
        w_enq_ok   = 1'b0;
        w_deq_ok   = 1'b0;
        w_flush    = 1'b0;
        w_res_load = 1'b0;
        n_pend     = r_pend;
        n_paused   = r_paused;
        w_res_d    = '{status: ST_OK, bid: '0, flen: '0, prio: '0,
                       paused: r_paused, pend: r_pend};
        if (r_state == BS_READ) begin
            w_res_load   = 1'b1;
            w_res_d.bid  = w_ram_rd[DESC_W-1:LEN_W];
            w_res_d.flen = w_ram_rd[LEN_W-1:0];
            w_res_d.prio = r_deq_q[OPRI_W-1:0];
        end else if (w_exec) begin
            w_res_load = 1'b1;
            unique case (i_cmd.kind)
                REQ_ENQ: begin
                    w_res_d.prio = w_q[OPRI_W-1:0];
                    // flow control is checked ahead of the full check
                    if (w_normal && r_pend >= i_max_pending) begin
                        n_paused       = 1'b1;
                        w_res_d.status = ST_BUSY;
                    end else if (r_occ[w_qi] == OCC_W'(QUEUE_DEPTH)) begin
                        w_res_d.status = ST_FULL;
                    end else begin
                        w_ram_we = 1'b1;
                        w_enq_ok = 1'b1;
                        if (w_normal && r_pend != '1) begin
                            n_pend = r_pend + 1'b1;
                        end
                    end
                end
                REQ_DEQ: begin
                    if (!w_found) begin
                        w_res_d.status = ST_EMPTY;
                    end else begin
                        // result loads after the store read
                        w_res_load = 1'b0;
                        w_ram_re   = 1'b1;
                        w_deq_ok   = 1'b1;
                        if (w_normal) begin
                            if (r_pend != '0) begin
                                n_pend = r_pend - 1'b1;
                            end
                            if (r_paused && n_pend < i_resume_thr) begin
                                n_paused = 1'b0;
                            end
                        end
                    end
                end
                REQ_FLUSH: begin
                    w_flush  = 1'b1;
                    n_pend   = '0;
                    n_paused = 1'b0;
                end
                REQ_NOP: begin
                end
                default: begin
                end
            endcase
            w_res_d.paused = n_paused;
            w_res_d.pend   = n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BS_IDLE;
            r_res_valid <= 1'b0;
            r_pend      <= '0;
            r_paused    <= 1'b0;
            for (int i = 0; i < NUM_PRIORITIES; i++) begin
                r_head[i] <= '0;
                r_tail[i] <= '0;
                r_occ[i]  <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_pend   <= n_pend;
            r_paused <= n_paused;
            if (w_res_load) begin
                r_res_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_res_valid <= 1'b0;
            end
            if (w_flush) begin
                for (int i = 0; i < NUM_PRIORITIES; i++) begin
                    r_head[i] <= '0;
                    r_tail[i] <= '0;
                    r_occ[i]  <= '0;
                end
            end else if (w_enq_ok) begin
                r_tail[w_qi] <= ptr_inc(r_tail[w_qi]);
                r_occ[w_qi]  <= r_occ[w_qi] + 1'b1;
            end else if (w_deq_ok) begin
                r_head[w_qi] <= ptr_inc(r_head[w_qi]);
                r_occ[w_qi]  <= r_occ[w_qi] - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_load) begin
            r_res <= w_res_d;
        end
        if (w_deq_ok) begin
            r_deq_q <= w_q;
        end
    end

    ptq_ram #(
        .WIDTH (DESC_W),
        .DEPTH (RAM_DEPTH)
    ) u_desc_ram (
        .i_clk     (i_clk),
        .i_wr_en   (w_ram_we),
        .i_wr_addr (w_addr),
        .i_wr_data ({i_cmd.bid, i_cmd.flen}),
        .i_rd_en   (w_ram_re),
        .i_rd_addr (w_addr),
        .o_rd_data (w_ram_rd)
    );

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

    // the result slot is free whenever a store read is in flight
    a_read_slot_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_READ) |-> !r_res_valid)
        else $error("result slot busy during descriptor read");

    a_read_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BS_READ) |=> (r_res_valid && r_state == BS_IDLE))
        else $error("dequeue result not loaded after descriptor read");

    a_pause_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_paused) |-> $past(w_exec && i_cmd.kind == REQ_ENQ))
        else $error("pause set by something other than an enqueue");

    a_pend_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_pend) <= 32'(r_occ[NORMAL_Q])))
        else $error("pending count exceeds normal queue occupancy");

endmodule

// File: rtl/priority_tx_queue_flow_control_core.sv
// Top level of the strict-priority transmit queue with flow control.
// Depends on ptq_pkg, ptq_front, ptq_back (and ptq_ram below it).
`timescale 1ns / 1ps
// An accepted request is queued in the front, then executed by the back end into the
//   result register (m_axis_tvalid); a dequeue that finds a descriptor adds the registered store read.
// Throughput: the back end takes one request per cycle while the result register is free or being taken,
//   but none during a dequeue's store read; a 2-deep request queue keeps the input side taking transactions until full.
// Reset (synchronous, active low): pointers, occupancy, pending count, pause and the
//   request queue cleared; registers to 100 / 20. Descriptor store not cleared.

module priority_tx_queue_flow_control_core import ptq_pkg::*; #(
    parameter int QUEUE_DEPTH    = QUEUE_DEPTH_DEF,
    parameter int NUM_PRIORITIES = NUM_PRIO_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request stream
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [TDATA_W-1:0]    s_axis_tdata,  // [7:0] priority_req, [15:8] buffer_id,
                                                 // [26:16] frame_length, rest zero
    input  logic [1:0]            s_axis_tuser,  // [1:0] req_type
    // result stream
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [TDATA_W-1:0]    m_axis_tdata,  // [7:0] out_buffer_id, [18:8] out_length,
                                                 // [20:19] out_priority, [21] paused_flag,
                                                 // [29:22] pending_count, rest zero
    output logic [1:0]            m_axis_tuser,  // [1:0] status
    // configuration port
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic [PEND_W-1:0] r_max_pending;
    logic [PEND_W-1:0] r_resume_thr;
    t_cfg_idx          w_cfg_idx;
    logic              w_cfg_wr;

    logic              w_cmd_valid;
    t_cmd              w_cmd;
    logic              w_cmd_pop;
    t_result           w_res;

    // Registers sit at byte addresses 0 and 4; only bit 2 picks one.
    assign w_cfg_idx = t_cfg_idx'(paddr[2]);
    assign pready    = 1'b1;
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_pending <= MAX_PENDING_RST;
            r_resume_thr  <= RESUME_THR_RST;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                CFG_MAX_PENDING: r_max_pending <= pwdata[PEND_W-1:0];
                CFG_RESUME_THR:  r_resume_thr  <= pwdata[PEND_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (w_cfg_idx)
            CFG_MAX_PENDING: prdata = APB_DATA_W'(r_max_pending);
            CFG_RESUME_THR:  prdata = APB_DATA_W'(r_resume_thr);
            default:         prdata = '0;
        endcase
    end

    // Front: takes each transaction, maps the priority, buffers the command.
    ptq_front #(
        .NUM_PRIORITIES (NUM_PRIORITIES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tvalid    (s_axis_tvalid),
        .o_tready    (s_axis_tready),
        .i_tuser     (s_axis_tuser),
        .i_tdata     (s_axis_tdata),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_pop   (w_cmd_pop)
    );

    // Back: carries out one command at a time into the result register.
    ptq_back #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .NUM_PRIORITIES (NUM_PRIORITIES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd_valid   (w_cmd_valid),
        .i_cmd         (w_cmd),
        .o_cmd_pop     (w_cmd_pop),
        .i_max_pending (r_max_pending),
        .i_resume_thr  (r_resume_thr),
        .o_res_valid   (m_axis_tvalid),
        .o_res         (w_res),
        .i_res_ready   (m_axis_tready)
    );

    assign m_axis_tuser = w_res.status;
    assign m_axis_tdata = {2'b00, w_res.pend, w_res.paused, w_res.prio, w_res.flen, w_res.bid};

endmodule
